>>> src/dcro_pkg.sv
package dcro_pkg;

  // Field widths
  localparam int DEPTH_W = 16;
  localparam int CAM_W   = 8;
  localparam int CH_W    = 8;
  localparam int MAG_W   = 15;   // |depth - depth_low| for a valid sample
  localparam int RECIP_W = 32;   // Q0.32 reciprocal of the depth range

  // Range divider: 32 quotient bits, one per cycle
  localparam int DIV_STEPS = RECIP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Tracker reset values
  localparam logic signed [DEPTH_W-1:0] DEPTH_LOW_INIT  = 16'sh7FFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_HIGH_INIT = 16'sh0000;

  localparam logic [CH_W-1:0] ALPHA_ON  = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_OFF = 8'h00;

  // Input action codes
  localparam logic ACT_MEASURE  = 1'b0;
  localparam logic ACT_COLORIZE = 1'b1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);

  // One classified colorize sample
  typedef struct packed {
    logic             ok;      // positive depth in a non-flat frame
    logic             neg;     // depth below depth_low
    logic [MAG_W-1:0] mag;     // |depth - depth_low|
    logic [CAM_W-1:0] cam_red;
    logic [CAM_W-1:0] cam_green;
    logic [CAM_W-1:0] cam_blue;
    logic             last;
  } qitem_t;

endpackage

>>> src/dcro_queue.sv
module dcro_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dcro_pkg::qitem_t push_item,
  input  logic             pop,
  output dcro_pkg::qitem_t head,
  output logic             full,
  output logic             empty
);

  dcro_pkg::qitem_t            mem [dcro_pkg::QDEPTH];
  logic [dcro_pkg::QIDX_W-1:0] wr_ptr;
  logic [dcro_pkg::QIDX_W-1:0] rd_ptr;
  logic [dcro_pkg::QIDX_W:0]   count;

  assign full  = (count == (dcro_pkg::QIDX_W + 1)'(dcro_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");

endmodule

>>> src/dcro_front.sv
module dcro_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [dcro_pkg::DEPTH_W-1:0] depth,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_red,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_green,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_blue,
  input  logic                                frame_end,
  input  logic                                q_full,
  input  logic                                q_empty,
  output logic                                q_push,
  output dcro_pkg::qitem_t                    q_item,
  output logic [dcro_pkg::RECIP_W-1:0]        range_recip
);

  typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_DIV} state_t;

  state_t                                state;
  logic signed [dcro_pkg::DEPTH_W-1:0]   depth_low;
  logic signed [dcro_pkg::DEPTH_W-1:0]   depth_high;
  logic                                  frame_flat;
  logic                                  pend_nonflat;
  logic [dcro_pkg::MAG_W-1:0]            div_den;
  logic [dcro_pkg::MAG_W-1:0]            div_rem;
  logic [dcro_pkg::RECIP_W-1:0]          div_quot;
  logic [dcro_pkg::DIV_CNT_W-1:0]        div_cnt;

  logic                                  acc;
  logic                                  d_pos;
  logic signed [dcro_pkg::DEPTH_W-1:0]   low_next;
  logic signed [dcro_pkg::DEPTH_W-1:0]   high_next;
  logic signed [dcro_pkg::DEPTH_W:0]     range_diff;
  logic signed [dcro_pkg::DEPTH_W:0]     pix_diff;
  logic [dcro_pkg::DEPTH_W:0]            pix_abs;
  logic [dcro_pkg::MAG_W:0]              trial;
  logic                                  qbit;
  logic [dcro_pkg::MAG_W-1:0]            rem_next;

  assign in_stall = (state != ST_RUN) || q_full;
  assign acc      = in_valid && !in_stall;
  assign q_push   = acc && (action == dcro_pkg::ACT_COLORIZE);
  assign d_pos    = !depth[dcro_pkg::DEPTH_W-1] && (|depth[dcro_pkg::DEPTH_W-2:0]);

  // Running min/max including the current sample
  always_comb begin
    low_next  = (d_pos && (depth < depth_low))  ? depth : depth_low;
    high_next = (d_pos && (depth > depth_high)) ? depth : depth_high;
    range_diff = {high_next[dcro_pkg::DEPTH_W-1], high_next}
               - {low_next[dcro_pkg::DEPTH_W-1], low_next};
  end

  // Classify a colorize sample against the latched frame statistics
  always_comb begin
    pix_diff = {depth[dcro_pkg::DEPTH_W-1], depth}
             - {depth_low[dcro_pkg::DEPTH_W-1], depth_low};
    pix_abs  = pix_diff[dcro_pkg::DEPTH_W] ? (-pix_diff) : pix_diff;
    q_item.ok        = d_pos && !frame_flat;
    q_item.neg       = pix_diff[dcro_pkg::DEPTH_W];
    q_item.mag       = pix_abs[dcro_pkg::MAG_W-1:0];
    q_item.cam_red   = cam_red;
    q_item.cam_green = cam_green;
    q_item.cam_blue  = cam_blue;
    q_item.last      = frame_end;
  end

  // Restoring divide step: dividend bits are all ones
  always_comb begin
    trial = {div_rem, 1'b1};
    qbit  = (trial >= {1'b0, div_den});
    rem_next = qbit ? dcro_pkg::MAG_W'(trial - {1'b0, div_den})
                    : trial[dcro_pkg::MAG_W-1:0];
  end

  // Sequencer: trackers, pass-end drain and range reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      depth_low    <= dcro_pkg::DEPTH_LOW_INIT;
      depth_high   <= dcro_pkg::DEPTH_HIGH_INIT;
      frame_flat   <= 1'b1;
      range_recip  <= '0;
      pend_nonflat <= 1'b0;
      div_den      <= '0;
      div_rem      <= '0;
      div_quot     <= '0;
      div_cnt      <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (acc && (action == dcro_pkg::ACT_MEASURE)) begin
            depth_low  <= low_next;
            depth_high <= high_next;
            if (frame_end) begin
              pend_nonflat <= (high_next > low_next);
              div_den      <= range_diff[dcro_pkg::MAG_W-1:0];
              state        <= ST_DRAIN;
            end
          end else if (acc && frame_end) begin
            depth_low  <= dcro_pkg::DEPTH_LOW_INIT;
            depth_high <= dcro_pkg::DEPTH_HIGH_INIT;
          end
        end
        ST_DRAIN: begin
          // queued samples still need the old reciprocal
          if (q_empty) begin
            if (pend_nonflat) begin
              div_rem <= '0;
              div_cnt <= dcro_pkg::DIV_CNT_W'(dcro_pkg::DIV_STEPS - 1);
              state   <= ST_DIV;
            end else begin
              range_recip <= '0;
              frame_flat  <= 1'b1;
              state       <= ST_RUN;
            end
          end
        end
        ST_DIV: begin
          div_rem  <= rem_next;
          div_quot <= {div_quot[dcro_pkg::RECIP_W-2:0], qbit};
          div_cnt  <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            range_recip <= {div_quot[dcro_pkg::RECIP_W-2:0], qbit};
            frame_flat  <= 1'b0;
            state       <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV) |-> (q_empty && !q_push))
    else $error("queue active while reciprocal is being formed");
  a_recip_held: assert property (@(posedge clk) disable iff (rst)
      (!q_empty && $past(!q_empty)) |-> $stable(range_recip))
    else $error("reciprocal changed under queued samples");

endmodule

>>> src/dcro_back.sv
module dcro_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dcro_pkg::qitem_t             head,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [dcro_pkg::RECIP_W-1:0] range_recip,
  input  logic                         overlay_enable,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dcro_pkg::CH_W-1:0]    out_red,
  output logic [dcro_pkg::CH_W-1:0]    out_green,
  output logic [dcro_pkg::CH_W-1:0]    out_blue,
  output logic [dcro_pkg::CH_W-1:0]    out_alpha,
  output logic                         out_last
);

  localparam int PROD_W = dcro_pkg::MAG_W + dcro_pkg::RECIP_W;
  localparam int SHR    = dcro_pkg::RECIP_W - FRAC_BITS;
  localparam int TR_W   = PROD_W + 1 - SHR;     // rounded t before clamp
  localparam int TM_W   = FRAC_BITS + 2;        // clamped |t|
  localparam int T_W    = FRAC_BITS + 3;        // signed t and ramp argument
  localparam int R_W    = FRAC_BITS + 1;        // ramp value, up to one
  localparam int SC_W   = FRAC_BITS + 9;        // scaled channel sum

  localparam logic [PROD_W:0]       ROUND_HALF = (PROD_W + 1)'(1) << (SHR - 1);
  localparam logic [TR_W-1:0]       T_LIMIT    = TR_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [T_W-1:0] ONE_Q      = T_W'(1) << FRAC_BITS;
  localparam logic signed [T_W-1:0] HALF_Q     = T_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [T_W-1:0] QTR_Q      = T_W'(1) << (FRAC_BITS - 2);
  localparam logic signed [T_W-1:0] QTR3_Q     = QTR_Q + HALF_Q;

  // Trapezoid ramp in Q.FRAC_BITS
  function automatic logic [R_W-1:0] ramp(input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0] w;
    w = '0;
    if (v <= -QTR3_Q) begin
      w = '0;
    end else if (v <= -QTR_Q) begin
      w = (v + QTR3_Q) <<< 1;
    end else if (v <= QTR_Q) begin
      w = ONE_Q;
    end else if (v <= QTR3_Q) begin
      w = (QTR3_Q - v) <<< 1;
    end
    return w[R_W-1:0];
  endfunction

  // ramp*255, optionally averaged with the camera value
  function automatic logic [dcro_pkg::CH_W-1:0] shade(input logic [R_W-1:0] r,
                                                      input logic [dcro_pkg::CAM_W-1:0] cam,
                                                      input logic ovl);
    logic [SC_W-1:0] scaled;
    logic [SC_W-1:0] sum;
    scaled = (SC_W'(r) << 8) - SC_W'(r);
    sum    = scaled + (SC_W'(cam) << FRAC_BITS);
    if (ovl) begin
      return sum[FRAC_BITS+8:FRAC_BITS+1];
    end
    return scaled[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // Stage 1: product |diff| * reciprocal
  logic                         s1_valid;
  logic [PROD_W-1:0]            s1_prod;
  dcro_pkg::qitem_t             s1_item;
  // Stage 2: signed t
  logic                         s2_valid;
  logic signed [T_W-1:0]        s2_t;
  dcro_pkg::qitem_t             s2_item;

  logic                         out_ready;
  logic                         s2_ready;
  logic                         s1_ready;
  logic [PROD_W:0]              rnd_sum;
  logic [TR_W-1:0]              t_raw;
  logic [TM_W-1:0]              t_mag;
  logic signed [T_W-1:0]        t_signed;

  // Stall chain
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign q_pop     = !q_empty && s1_ready;

  // Round, clamp and sign
  always_comb begin
    rnd_sum  = {1'b0, s1_prod} + ROUND_HALF;
    t_raw    = rnd_sum[PROD_W:SHR];
    t_mag    = (t_raw > T_LIMIT) ? T_LIMIT[TM_W-1:0] : t_raw[TM_W-1:0];
    t_signed = s1_item.neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_pop;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod <= PROD_W'(head.mag) * PROD_W'(range_recip);
      s1_item <= head;
    end
    if (s1_valid && s2_ready) begin
      s2_t    <= t_signed;
      s2_item <= s1_item;
    end
    if (s2_valid && out_ready) begin
      out_last <= s2_item.last;
      if (s2_item.ok) begin
        out_red   <= shade(ramp(s2_t - HALF_Q), s2_item.cam_red, overlay_enable);
        out_green <= shade(ramp(s2_t), s2_item.cam_green, overlay_enable);
        out_blue  <= shade(ramp(s2_t + HALF_Q), s2_item.cam_blue, overlay_enable);
        out_alpha <= dcro_pkg::ALPHA_ON;
      end else begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_alpha <= dcro_pkg::ALPHA_OFF;
      end
    end
  end

  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (out_alpha == dcro_pkg::ALPHA_ON || out_alpha == dcro_pkg::ALPHA_OFF))
    else $error("alpha is neither on nor off");
  a_dark_blank: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_alpha == dcro_pkg::ALPHA_OFF)
        |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("invalid pixel carries color");

endmodule

>>> src/depth_to_color_ramp_overlay.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  action, depth, cam_red/green/blue, frame_end
// out       output     out_valid/out_stall  out_red/green/blue, out_alpha, out_last
// cfg       input      cfg_valid/cfg_ready  cfg_data -> overlay_enable
//
// Measure and colorize samples are taken one per cycle while in_stall is low;
// a colorize result is registered in the queue, stage 1, stage 2 and the output stage.
// A measure frame_end holds in_stall high while the queue empties, then while the
// bit-serial range divider runs; a flat frame skips the divider.
// Synchronous active-high reset: overlay on, trackers at their reset values, frame flat.
// A 4-entry queue decouples input from the output pipeline; out_stall backs
// up through the pipeline into the queue, and in_stall rises when it is full.
module depth_to_color_ramp_overlay #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [dcro_pkg::DEPTH_W-1:0] depth,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_red,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_green,
  input  logic [dcro_pkg::CAM_W-1:0]          cam_blue,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dcro_pkg::CH_W-1:0]           out_red,
  output logic [dcro_pkg::CH_W-1:0]           out_green,
  output logic [dcro_pkg::CH_W-1:0]           out_blue,
  output logic [dcro_pkg::CH_W-1:0]           out_alpha,
  output logic                                out_last
);

  logic                         overlay_enable;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  dcro_pkg::qitem_t             q_item;
  dcro_pkg::qitem_t             q_head;
  logic [dcro_pkg::RECIP_W-1:0] range_recip;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      overlay_enable <= cfg_data;
    end
  end

  dcro_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .depth       (depth),
    .cam_red     (cam_red),
    .cam_green   (cam_green),
    .cam_blue    (cam_blue),
    .frame_end   (frame_end),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .q_push      (q_push),
    .q_item      (q_item),
    .range_recip (range_recip)
  );

  dcro_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dcro_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .range_recip    (range_recip),
    .overlay_enable (overlay_enable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_last       (out_last)
  );

endmodule
